FILE: rtl/mbc1_pkg.sv
// shared types and constants of the mbc1 bank controller
package mbc1_pkg;

    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 2;
    localparam int MEM_ADDR_W = 21;

    // low nibble of the ram gate register that opens sram
    localparam logic [3:0] GATE_KEY    = 4'hA;
    // address bits 15:13 of the sram window 0xa000..0xbfff
    localparam logic [2:0] SRAM_REGION = 3'b101;

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_SRAM = 2'd1,
        TGT_NONE = 2'd2,
        TGT_BANK = 2'd3
    } target_t;

    // bank register picked by address bits 14:13 of a write below 0x8000
    typedef enum logic [1:0] {
        REG_GATE     = 2'd0,
        REG_ROM_LOW  = 2'd1,
        REG_ROM_HIGH = 2'd2,
        REG_MODE     = 2'd3
    } bank_reg_t;

    typedef enum logic [1:0] {
        CFG_ROM_COUNT   = 2'd0,
        CFG_RAM_COUNT   = 2'd1,
        CFG_RAM_PRESENT = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } access_t;

    typedef struct packed {
        target_t                 target;
        logic [MEM_ADDR_W-1:0]   mem_addr;
        logic                    write_strobe;
        logic [7:0]              store_data;
        logic                    open_bus;
        logic                    sram_enabled;
        logic                    banking_mode;
    } result_t;

    // only the bits of the bank registers that the mapper looks at are kept
    typedef struct packed {
        logic [3:0]            ram_gate;
        logic [4:0]            rom_low;
        logic [1:0]            rom_high;
        logic                  mode;
        logic                  sram_on;
        logic [ROM_BANK_W-1:0] upper;
        logic [ROM_BANK_W-1:0] lower;
        logic [RAM_BANK_W-1:0] ram_bank;
    } bank_state_t;

    typedef struct packed {
        logic      recompute;
        logic      load;
        bank_reg_t sel;
        logic [7:0] data;
    } bank_upd_t;

endpackage

FILE: rtl/mbc1_acc_if.sv
// bus access channel of the mbc1 bank controller
interface mbc1_acc_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output action, output address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input address, input write_data,
                    output ready);
endinterface

FILE: rtl/mbc1_res_if.sv
// translated result channel of the mbc1 bank controller
interface mbc1_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target;
    logic [20:0] mem_addr;
    logic        write_strobe;
    logic [7:0]  store_data;
    logic        open_bus;
    logic        sram_enabled;
    logic        banking_mode;

    modport source (output valid, output target, output mem_addr, output write_strobe,
                    output store_data, output open_bus, output sram_enabled,
                    output banking_mode, input ready);
    modport sink   (input valid, input target, input mem_addr, input write_strobe,
                    input store_data, input open_bus, input sram_enabled,
                    input banking_mode, output ready);
endinterface

FILE: rtl/mbc1_bank_file.sv
// bank registers of the mbc1 controller and the recompute of the derived banks
module mbc1_bank_file (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  mbc1_pkg::bank_upd_t   upd,
    input  logic [7:0]            rom_bank_count,
    input  logic [2:0]            ram_bank_count,
    output mbc1_pkg::bank_state_t state_cur,
    output mbc1_pkg::bank_state_t state_nxt
);
    import mbc1_pkg::*;

    // everything clear except the romx bank, which starts at 1
    localparam bank_state_t STATE_RESET = '{ram_gate: 4'd0,
                                            rom_low:  5'd0,
                                            rom_high: 2'd0,
                                            mode:     1'b0,
                                            sram_on:  1'b0,
                                            upper:    ROM_BANK_W'(1),
                                            lower:    ROM_BANK_W'(0),
                                            ram_bank: RAM_BANK_W'(0)};

    bank_state_t state_reg;
    bank_state_t state_next;

    always_comb
    begin
        logic [ROM_BANK_W-1:0] romx;
        logic [ROM_BANK_W-1:0] rom0;
        logic [RAM_BANK_W-1:0] rb;
        logic [7:0]            rmask;
        logic [2:0]            mmask;

        state_next = state_reg;
        romx  = '0;
        rom0  = '0;
        rb    = '0;
        rmask = rom_bank_count - 8'd1;
        mmask = ram_bank_count - 3'd1;

        if (upd.load)
        begin
            unique case (upd.sel)
                REG_GATE:     state_next.ram_gate = upd.data[3:0];
                REG_ROM_LOW:  state_next.rom_low  = upd.data[4:0];
                REG_ROM_HIGH: state_next.rom_high = upd.data[1:0];
                REG_MODE:     state_next.mode     = upd.data[0];
                default:      state_next.mode     = state_reg.mode;
            endcase
        end

        if (upd.recompute)
        begin
            state_next.sram_on = (state_next.ram_gate == GATE_KEY);
            // bank 0 in the low field maps to bank 1
            romx = {state_next.rom_high,
                    (state_next.rom_low == 5'd0) ? 5'd1 : state_next.rom_low};
            rom0 = state_next.mode ? {state_next.rom_high, 5'd0} : '0;
            rb   = state_next.mode ? state_next.rom_high : '0;
            if ({1'b0, romx} > rmask)
            begin
                romx = romx & rmask[ROM_BANK_W-1:0];
                rom0 = rom0 & rmask[ROM_BANK_W-1:0];
            end
            if ({1'b0, rb} > mmask)
            begin
                rb = rb & mmask[RAM_BANK_W-1:0];
            end
            state_next.upper    = romx;
            state_next.lower    = rom0;
            state_next.ram_bank = rb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign state_cur = state_reg;
    assign state_nxt = state_next;

endmodule

FILE: rtl/mbc1_xlate.sv
// address decode and translation of one cartridge bus access
module mbc1_xlate (
    input  mbc1_pkg::access_t     acc,
    input  mbc1_pkg::bank_state_t state_cur,
    input  mbc1_pkg::bank_state_t state_nxt,
    input  logic                  ram_present,
    output mbc1_pkg::bank_upd_t   upd,
    output mbc1_pkg::result_t     res
);
    import mbc1_pkg::*;

    logic                  in_sram;
    logic                  sram_ok;
    logic [MEM_ADDR_W-1:0] sram_addr;
    logic [MEM_ADDR_W-1:0] rom_addr;

    assign in_sram   = (acc.address[15:13] == SRAM_REGION);
    assign sram_ok   = ram_present & state_cur.sram_on;
    assign sram_addr = {{(MEM_ADDR_W-RAM_BANK_W-13){1'b0}}, state_cur.ram_bank,
                        acc.address[12:0]};
    assign rom_addr  = acc.address[14] ? {state_cur.upper, acc.address[13:0]}
                                       : {state_cur.lower, acc.address[13:0]};

    always_comb
    begin
        res        = '0;
        res.target = TGT_NONE;
        upd        = '0;
        upd.sel    = REG_GATE;

        if (acc.action)
        begin
            if (in_sram)
            begin
                if (sram_ok)
                begin
                    res.target       = TGT_SRAM;
                    res.mem_addr     = sram_addr;
                    res.write_strobe = 1'b1;
                    res.store_data   = acc.write_data;
                end
                upd.recompute = 1'b1;
            end
            else if (!acc.address[15])
            begin
                upd.load      = 1'b1;
                upd.sel       = bank_reg_t'(acc.address[14:13]);
                upd.data      = acc.write_data;
                upd.recompute = 1'b1;
                res.target    = TGT_BANK;
            end
        end
        else
        begin
            if (!acc.address[15])
            begin
                res.target   = TGT_ROM;
                res.mem_addr = rom_addr;
            end
            else if (in_sram && sram_ok)
            begin
                res.target   = TGT_SRAM;
                res.mem_addr = sram_addr;
            end
            else
            begin
                res.open_bus = 1'b1;
            end
        end

        // status reflects the state left by this access
        res.sram_enabled = state_nxt.sram_on;
        res.banking_mode = state_nxt.mode;
    end

endmodule

FILE: rtl/mbc1_bank_controller_unit.sv
// top level of the mbc1 cartridge bank controller
//
// usage
//  - acc carries one cartridge bus access per word: action (0 read, 1 write),
//    16-bit address and the data byte of a write
//  - res returns exactly one word per access: target, physical rom or sram
//    byte address, sram write strobe and byte, open bus flag, and the sram
//    gate and banking mode left after the access
//  - cfg_we/cfg_index/cfg_data load rom_bank_count (0), ram_bank_count (1)
//    and ram_present (2); index 3 is ignored; write only while idle
// timing
//  - an access lands in the input register, is translated and updates the
//    bank registers in one pass, and sits in the result register after that
//  - throughput one access per cycle while res.ready is high; bank register writes take effect for
//    the very next access
// reset
//  - bank registers clear, romx bank is 1, counts go to 2 rom banks, 1 ram
//    bank, no sram; both pipeline registers empty
// stall
//  - with res.ready low the result holds and one more access waits in the
//    input register; acc.ready then drops until res drains
module mbc1_bank_controller_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  mbc1_pkg::cfg_idx_t   cfg_index,
    input  logic [7:0]           cfg_data,
    mbc1_acc_if.sink             acc,
    mbc1_res_if.source           res
);
    import mbc1_pkg::*;

    // configuration registers
    logic [7:0]  rom_count_reg;
    logic [2:0]  ram_count_reg;
    logic        ram_present_reg;

    // input stage
    access_t     acc_reg;
    logic        acc_valid_reg;
    logic        acc_valid_next;

    // result stage
    result_t     res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;

    logic        advance;
    logic        acc_take;
    bank_upd_t   upd;
    bank_state_t state_cur;
    bank_state_t state_nxt;
    result_t     res_calc;
    access_t     acc_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_count_reg   <= 8'd2;
            ram_count_reg   <= 3'd1;
            ram_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROM_COUNT:   rom_count_reg   <= cfg_data;
                CFG_RAM_COUNT:   ram_count_reg   <= cfg_data[2:0];
                CFG_RAM_PRESENT: ram_present_reg <= cfg_data[0];
                default:         ram_present_reg <= ram_present_reg;
            endcase
        end
    end

    // the translate stage moves when the result register is free or draining
    assign advance   = acc_valid_reg && (!res_valid_reg || res.ready);
    assign acc.ready = !acc_valid_reg || advance;
    assign acc_take  = acc.valid && acc.ready;

    assign acc_word.action     = acc.action;
    assign acc_word.address    = acc.address;
    assign acc_word.write_data = acc.write_data;

    assign acc_valid_next = acc_take || (acc_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (acc_take)
        begin
            acc_reg <= acc_word;
        end
        if (advance)
        begin
            res_reg <= res_calc;
        end
    end

    mbc1_bank_file u_bank_file (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .upd            (upd),
        .rom_bank_count (rom_count_reg),
        .ram_bank_count (ram_count_reg),
        .state_cur      (state_cur),
        .state_nxt      (state_nxt)
    );

    mbc1_xlate u_xlate (
        .acc         (acc_reg),
        .state_cur   (state_cur),
        .state_nxt   (state_nxt),
        .ram_present (ram_present_reg),
        .upd         (upd),
        .res         (res_calc)
    );

    assign res.valid        = res_valid_reg;
    assign res.target       = res_reg.target;
    assign res.mem_addr     = res_reg.mem_addr;
    assign res.write_strobe = res_reg.write_strobe;
    assign res.store_data   = res_reg.store_data;
    assign res.open_bus     = res_reg.open_bus;
    assign res.sram_enabled = res_reg.sram_enabled;
    assign res.banking_mode = res_reg.banking_mode;

endmodule

FILE: tb/mbc1_tb_pkg.sv
// translation predictor and result board for the mbc1 bank controller testbench
package mbc1_tb_pkg;

    import mbc1_pkg::*;

    class bank_xlate_board;

        // cartridge configuration
        logic [7:0] rom_count;
        logic [2:0] ram_count;
        logic       present;

        // mapper registers and derived banks
        logic [7:0]            gate_reg;
        logic [7:0]            low_reg;
        logic [7:0]            high_reg;
        logic [7:0]            mode_reg;
        logic                  sram_on;
        logic [ROM_BANK_W-1:0] upper_bank;
        logic [ROM_BANK_W-1:0] lower_bank;
        logic [RAM_BANK_W-1:0] ram_bank_sel;

        result_t expected_xlate[$];
        int      error_count;

        function new();
            rom_count    = 8'd2;
            ram_count    = 3'd1;
            present      = 1'b0;
            gate_reg     = '0;
            low_reg      = '0;
            high_reg     = '0;
            mode_reg     = '0;
            sram_on      = 1'b0;
            upper_bank   = 7'd1;
            lower_bank   = '0;
            ram_bank_sel = '0;
            error_count  = 0;
        endfunction

        function void set_config(cfg_idx_t idx, logic [7:0] value);
            case (idx)
                CFG_ROM_COUNT:   rom_count = value;
                CFG_RAM_COUNT:   ram_count = value[2:0];
                CFG_RAM_PRESENT: present   = value[0];
                default: ;
            endcase
        endfunction

        function void rebank();
            logic [7:0] romx;
            logic [7:0] rom0;
            logic [7:0] rmask;
            logic [2:0] rb;
            logic [2:0] mmask;
            logic [1:0] hi;
            sram_on = (gate_reg[3:0] == GATE_KEY);
            romx = {3'b000, low_reg[4:0]};
            if (romx == 8'd0)
                romx = 8'd1;
            hi = high_reg[1:0];
            romx = romx | {1'b0, hi, 5'b00000};
            if (!mode_reg[0])
            begin
                rom0 = 8'd0;
                rb   = 3'd0;
            end
            else
            begin
                rom0 = {1'b0, hi, 5'b00000};
                rb   = {1'b0, hi};
            end
            // a zero count wraps to all ones and masks nothing
            rmask = rom_count - 8'd1;
            if (romx > rmask)
            begin
                romx = romx & rmask;
                rom0 = rom0 & rmask;
            end
            mmask = ram_count - 3'd1;
            if (rb > mmask)
                rb = rb & mmask;
            upper_bank   = romx[6:0];
            lower_bank   = rom0[6:0];
            ram_bank_sel = rb[1:0];
        endfunction

        function result_t translate(access_t a);
            result_t r;
            logic    in_sram;
            r        = '0;
            r.target = TGT_NONE;
            in_sram  = (a.address[15:13] == SRAM_REGION);
            if (a.action)
            begin
                if (in_sram)
                begin
                    if (present && sram_on)
                    begin
                        r.target       = TGT_SRAM;
                        r.mem_addr     = {6'd0, ram_bank_sel, a.address[12:0]};
                        r.write_strobe = 1'b1;
                        r.store_data   = a.write_data;
                    end
                    rebank();
                end
                else if (!a.address[15])
                begin
                    case (bank_reg_t'(a.address[14:13]))
                        REG_GATE:     gate_reg = a.write_data;
                        REG_ROM_LOW:  low_reg  = a.write_data;
                        REG_ROM_HIGH: high_reg = a.write_data;
                        default:      mode_reg = a.write_data;
                    endcase
                    r.target = TGT_BANK;
                    rebank();
                end
            end
            else
            begin
                if (!a.address[15] && !a.address[14])
                begin
                    r.target   = TGT_ROM;
                    r.mem_addr = {lower_bank, a.address[13:0]};
                end
                else if (!a.address[15])
                begin
                    r.target   = TGT_ROM;
                    r.mem_addr = {upper_bank, a.address[13:0]};
                end
                else if (in_sram && present && sram_on)
                begin
                    r.target   = TGT_SRAM;
                    r.mem_addr = {6'd0, ram_bank_sel, a.address[12:0]};
                end
                else
                    r.open_bus = 1'b1;
            end
            r.sram_enabled = sram_on;
            r.banking_mode = mode_reg[0];
            return r;
        endfunction

        function void note_access(access_t a);
            expected_xlate.push_back(translate(a));
        endfunction

        function int pending();
            return expected_xlate.size();
        endfunction

        task report(string msg);
            if (error_count < 40)
                $display("mbc1 check: %s", msg);
            error_count++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_xlate.size() == 0)
            begin
                report("result word with no access waiting");
                return;
            end
            want = expected_xlate.pop_front();
            check_field("target", 32'(got.target), 32'(want.target));
            check_field("mem_addr", 32'(got.mem_addr), 32'(want.mem_addr));
            check_field("write_strobe", 32'(got.write_strobe), 32'(want.write_strobe));
            check_field("store_data", 32'(got.store_data), 32'(want.store_data));
            check_field("open_bus", 32'(got.open_bus), 32'(want.open_bus));
            check_field("sram_enabled", 32'(got.sram_enabled), 32'(want.sram_enabled));
            check_field("banking_mode", 32'(got.banking_mode), 32'(want.banking_mode));
        endtask

        task check_drained();
            if (expected_xlate.size() != 0)
                report($sformatf("%0d result words never arrived", expected_xlate.size()));
        endtask

    endclass

endpackage

FILE: tb/tb_mbc1_bank_controller_unit.sv
// top level testbench of the mbc1 bank controller unit
module tb_mbc1_bank_controller_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mbc1_pkg::*;
    import mbc1_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int WORDS_PER_PASS = 190;
    localparam int NUM_PASSES     = 8;
    localparam int HOLD_CYCLES    = 300;
    // slack after the last result word before touching config
    localparam int SETTLE_CYCLES  = 4;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    logic [7:0] cfg_data;

    mbc1_acc_if acc_ch ();
    mbc1_res_if res_ch ();

    mbc1_bank_controller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (acc_ch),
        .res       (res_ch)
    );

    bank_xlate_board board;

    int cycle_count;
    int burst_left;
    bit hold_request;

    // cartridge settings per random pass: extremes, zero counts, odd counts
    logic [7:0] pass_rom_count [NUM_PASSES] = '{8'd2, 8'd128, 8'd0, 8'd6,
                                                8'd64, 8'd32, 8'd16, 8'd4};
    logic [2:0] pass_ram_count [NUM_PASSES] = '{3'd1, 3'd4, 3'd0, 3'd3,
                                                3'd2, 3'd7, 3'd4, 3'd1};
    logic       pass_present   [NUM_PASSES] = '{1'b0, 1'b1, 1'b1, 1'b1,
                                                1'b1, 1'b1, 1'b0, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle counter, ends a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mbc1_bank_controller_unit: mismatch");
        $finish;
    end

    function automatic access_t mk_access(logic act, logic [15:0] addr, logic [7:0] data);
        access_t a;
        a.action     = act;
        a.address    = addr;
        a.write_data = data;
        return a;
    endfunction

    // mostly mapper traffic with random content, a little unmapped noise
    function automatic access_t random_access();
        int          pick;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        act;
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        addr = 16'($urandom_range(0, 16'h1fff));
        act  = 1'b1;
        if (pick < 12)
        begin
            // gate writes open the sram more often than not
            if ($urandom_range(0, 9) < 6)
                data[3:0] = GATE_KEY;
        end
        else if (pick < 24)
            addr = 16'h2000 + addr;
        else if (pick < 32)
            addr = 16'h4000 + addr;
        else if (pick < 38)
        begin
            addr = 16'h6000 + addr;
        end
        else if (pick < 50)
            addr = 16'ha000 + addr;
        else if (pick < 65)
        begin
            act  = 1'b0;
            addr = 16'($urandom_range(0, 16'h3fff));
        end
        else if (pick < 80)
        begin
            act  = 1'b0;
            addr = 16'($urandom_range(16'h4000, 16'h7fff));
        end
        else if (pick < 92)
        begin
            act  = 1'b0;
            addr = 16'ha000 + addr;
        end
        else
        begin
            // unmapped windows, read or dropped write
            act = (pick >= 96);
            if ($urandom_range(0, 1) == 0)
                addr = 16'h8000 + addr;
            else
                addr = 16'($urandom_range(16'hc000, 16'hffff));
        end
        return mk_access(act, addr, data);
    endfunction

    // offer one word, then hold until the block takes it
    task automatic send_word(access_t a);
        acc_ch.valid      <= 1'b1;
        acc_ch.action     <= a.action;
        acc_ch.address    <= a.address;
        acc_ch.write_data <= a.write_data;
        do
            @(posedge clk);
        while (!acc_ch.ready);
        board.note_access(a);
    endtask

    // sender works in bursts with random gaps in between
    task automatic offer(access_t a);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                acc_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_word(a);
    endtask

    // stop sending and wait for every result word to come back
    task automatic settle();
        acc_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one write per edge, enable stays high across the sequence
    task automatic write_config(logic [7:0] rom_cnt, logic [2:0] ram_cnt, logic has_ram);
        logic [7:0] value;
        cfg_idx_t   idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_t'(i);
            case (idx)
                CFG_ROM_COUNT:   value = rom_cnt;
                CFG_RAM_COUNT:   value = {5'($urandom_range(0, 31)), ram_cnt};
                CFG_RAM_PRESENT: value = {7'($urandom_range(0, 127)), has_ram};
                default:         value = 8'($urandom_range(0, 255));
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            board.set_config(idx, value);
        end
        cfg_we <= 1'b0;
    endtask

    // receiver: checks each taken word and stalls on its own pattern
    initial
    begin : result_side
        int      hold_left;
        int      seg_left;
        int      mode;
        int      stride;
        int      phase;
        logic    rdy;
        result_t got;
        hold_left = 0;
        seg_left  = 0;
        mode      = 0;
        stride    = 2;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.target       = target_t'(res_ch.target);
                got.mem_addr     = res_ch.mem_addr;
                got.write_strobe = res_ch.write_strobe;
                got.store_data   = res_ch.store_data;
                got.open_bus     = res_ch.open_bus;
                got.sram_enabled = res_ch.sram_enabled;
                got.banking_mode = res_ch.banking_mode;
                board.check_result(got);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // long hold-off so both pipeline slots fill and acc stalls
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    stride   = $urandom_range(2, 5);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                phase++;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) == 1);
                    2:       rdy = ((phase % stride) == 0);
                    default: rdy = ($urandom_range(0, 9) != 0);
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    // main sequence: reset, directed words, then random passes per setting
    initial
    begin : stimulus
        access_t directed[$];
        board        = new();
        burst_left   = 0;
        hold_request = 1'b0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_ROM_COUNT;
        cfg_data          <= 8'd0;
        acc_ch.valid      <= 1'b0;
        acc_ch.action     <= 1'b0;
        acc_ch.address    <= 16'd0;
        acc_ch.write_data <= 8'd0;
        res_ch.ready      <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(8'd128, 3'd4, 1'b1);

        // rom window edges with reset banks
        directed.push_back(mk_access(1'b0, 16'h0000, 8'h00));
        directed.push_back(mk_access(1'b0, 16'h3fff, 8'hff));
        directed.push_back(mk_access(1'b0, 16'h4000, 8'h00));
        directed.push_back(mk_access(1'b0, 16'h7fff, 8'hff));
        // sram gated off: open bus read, write dropped but still rebanks
        directed.push_back(mk_access(1'b0, 16'ha000, 8'h00));
        directed.push_back(mk_access(1'b1, 16'ha000, 8'h55));
        // open the gate, store and read back at the top of the window
        directed.push_back(mk_access(1'b1, 16'h0000, 8'h0a));
        directed.push_back(mk_access(1'b1, 16'hbfff, 8'hff));
        directed.push_back(mk_access(1'b0, 16'hbfff, 8'h00));
        // low bank zero maps to one, then full low and high bank
        directed.push_back(mk_access(1'b1, 16'h2000, 8'h00));
        directed.push_back(mk_access(1'b0, 16'h4000, 8'h00));
        directed.push_back(mk_access(1'b1, 16'h3fff, 8'hff));
        directed.push_back(mk_access(1'b1, 16'h4000, 8'hff));
        directed.push_back(mk_access(1'b0, 16'h7fff, 8'h00));
        // mode 1 moves rom0 and selects the ram bank
        directed.push_back(mk_access(1'b1, 16'h6000, 8'h01));
        directed.push_back(mk_access(1'b0, 16'h0000, 8'h00));
        directed.push_back(mk_access(1'b0, 16'ha000, 8'h00));
        // unmapped windows
        directed.push_back(mk_access(1'b1, 16'h8000, 8'haa));
        directed.push_back(mk_access(1'b1, 16'hffff, 8'h00));
        directed.push_back(mk_access(1'b0, 16'h9fff, 8'h00));
        directed.push_back(mk_access(1'b0, 16'hc000, 8'hff));
        // gate key in the wrong nibble closes the sram
        directed.push_back(mk_access(1'b1, 16'h1fff, 8'ha5));
        directed.push_back(mk_access(1'b0, 16'ha000, 8'h00));
        // back to mode 0 from the top of the mode window
        directed.push_back(mk_access(1'b1, 16'h7fff, 8'hfe));
        directed.push_back(mk_access(1'b0, 16'h0000, 8'h00));
        foreach (directed[i])
            offer(directed[i]);

        for (int p = 0; p < NUM_PASSES; p++)
        begin
            settle();
            write_config(pass_rom_count[p], pass_ram_count[p], pass_present[p]);
            for (int i = 0; i < WORDS_PER_PASS; i++)
            begin
                // once per run the receiver backs off while we keep offering
                if (p == 2 && i == 20)
                    hold_request = 1'b1;
                offer(random_access());
            end
        end

        settle();
        repeat (8) @(posedge clk);
        board.check_drained();
        if (board.error_count == 0)
            $display("mbc1_bank_controller_unit: match");
        else
            $display("mbc1_bank_controller_unit: mismatch");
        $finish;
    end

endmodule
